// ----- src/rrab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrab_pkg
// Shared constants for the rounded-rectangle coverage and blend pipeline.
// ----------------------------------------------------------------------------
package rrab_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTLINE_MODE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STROKE_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PAINT_COLOR   = 3'd7;

  localparam logic [CH_W-1:0] STROKE_RESET = 8'd1;

  // floor(m / 255) == (m * RECIP_255) >> RECIP_SHIFT for m <= 255 * 255
  localparam logic [15:0] RECIP_255   = 16'd32897;
  localparam int          RECIP_SHIFT = 23;
  localparam logic [CH_W-1:0] CH_MAX  = 8'd255;

endpackage

// ----- src/rrab_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrab_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module rrab_isqrt #(
  parameter int RW = 23
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] radicand,
  output logic [RW-1:0]   root
);

  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] sh_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0]   rem_prev;
    logic [RW-1:0]   root_prev;
    logic [2*RW-1:0] sh_prev;
    logic [RW+2:0]   cur;
    logic [RW+2:0]   trial;

    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign sh_prev   = radicand;
    end else begin : g_rest
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
      assign sh_prev   = sh_q[k-1];
    end

    assign cur   = {rem_prev[RW:0], sh_prev[2*RW-1 -: 2]};
    assign trial = {1'b0, root_prev, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_q[k]  <= (RW+2)'(cur - trial);
          root_q[k] <= {root_prev[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cur[RW+1:0];
          root_q[k] <= {root_prev[RW-2:0], 1'b0};
        end
        sh_q[k] <= {sh_prev[2*RW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

// ----- src/rrab_sdf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrab_sdf
// Rounded-rectangle signed distance at a doubled point, FB fraction bits.
// ----------------------------------------------------------------------------
module rrab_sdf #(
  parameter int CB = 12,
  parameter int FB = 8,
  parameter int SW = CB + 5,
  parameter int QW = CB + 3,
  parameter int RW = QW + FB,
  parameter int DW = RW + 3
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [SW-1:0] p2x,
  input  logic signed [SW-1:0] p2y,
  input  logic signed [SW-1:0] cx,
  input  logic signed [SW-1:0] cy,
  input  logic signed [SW-1:0] hx,
  input  logic signed [SW-1:0] hy,
  input  logic [CB-2:0]        rad,
  output logic signed [DW-1:0] distance
);

  logic signed [SW-1:0] difx, dify, absx, absy;
  logic signed [SW-1:0] qx, qy, mx;
  logic [QW-1:0]        qxp, qyp;
  logic [2*QW-1:0]      sqx, sqy;
  logic signed [SW-1:0] ins_b, ins_c;
  logic signed [SW-1:0] ins_q [RW];
  logic [2*RW-1:0]      rad_sum;
  logic [RW-1:0]        root;

  assign difx = p2x - cx;
  assign dify = p2y - cy;
  assign absx = difx[SW-1] ? -difx : difx;
  assign absy = dify[SW-1] ? -dify : dify;

  always_ff @(posedge clk) begin
    if (en) begin
      qx <= absx - hx;
      qy <= absy - hy;
    end
  end

  assign qxp = qx[SW-1] ? '0 : qx[QW-1:0];
  assign qyp = qy[SW-1] ? '0 : qy[QW-1:0];
  assign mx  = (qx > qy) ? qx : qy;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx   <= (2*QW)'(qxp) * (2*QW)'(qxp);
      sqy   <= (2*QW)'(qyp) * (2*QW)'(qyp);
      ins_b <= mx[SW-1] ? mx : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_sum <= ((2*RW)'({1'b0, sqx}) + (2*RW)'({1'b0, sqy})) << (2*(FB-1));
      ins_c   <= ins_b;
    end
  end

  rrab_isqrt #(.RW(RW)) u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (rad_sum),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ins_q[0] <= ins_c;
      for (int i = 1; i < RW; i++) ins_q[i] <= ins_q[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distance <= DW'({1'b0, root}) + (DW'(ins_q[RW-1]) <<< (FB-1))
                  - DW'({rad, {FB{1'b0}}});
    end
  end

endmodule

// ----- src/rounded_rect_aa_raster_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_aa_raster_blend
// Anti-aliased rounded-rectangle fill or outline, blended over a pixel stream.
// ----------------------------------------------------------------------------
// Each accepted transaction passes the signed-distance units, including the
//   one-bit-per-stage square root pipeline, then the blend stages and buffer.
// Throughput: one transaction per cycle; a two-entry output buffer absorbs
//   backpressure, and input stalls only when that buffer is full.
// Reset: synchronous; clears valid bits and buffer count and loads register
//   defaults (stroke width 1, all others 0). No clearing pass.
// ----------------------------------------------------------------------------
module rounded_rect_aa_raster_blend
  import rrab_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [PIX_W-1:0]      dest_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      new_pixel,
  output logic                  touched
);

  localparam int CB  = COORD_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int SW  = CB + 5;
  localparam int QW  = CB + 3;
  localparam int RW  = QW + FB;
  localparam int DW  = RW + 3;
  localparam int LSD = RW + 4;
  localparam int WW  = FB + CH_W;
  localparam logic signed [DW-1:0] HALF_D = DW'(1) << (FB - 1);
  localparam logic signed [DW-1:0] ONE_D  = DW'(1) << FB;
  localparam logic [FB:0]          ONE_C  = (FB+1)'(1) << FB;
  localparam logic [WW-1:0]        DEN    = WW'(CH_MAX) << FB;

  logic [CB-1:0]    rect_left, rect_top;
  logic [CB:0]      rect_width, rect_height;
  logic [CB-2:0]    corner_radius;
  logic             outline_mode;
  logic [CH_W-1:0]  stroke_width;
  logic [PIX_W-1:0] paint_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left     <= '0;
      rect_top      <= '0;
      rect_width    <= '0;
      rect_height   <= '0;
      corner_radius <= '0;
      outline_mode  <= 1'b0;
      stroke_width  <= STROKE_RESET;
      paint_color   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RECT_LEFT:     rect_left     <= cfg_data[CB-1:0];
        CFG_RECT_TOP:      rect_top      <= cfg_data[CB-1:0];
        CFG_RECT_WIDTH:    rect_width    <= cfg_data[CB:0];
        CFG_RECT_HEIGHT:   rect_height   <= cfg_data[CB:0];
        CFG_CORNER_RADIUS: corner_radius <= cfg_data[CB-2:0];
        CFG_OUTLINE_MODE:  outline_mode  <= cfg_data[0];
        CFG_STROKE_WIDTH:  stroke_width  <= cfg_data[CH_W-1:0];
        CFG_PAINT_COLOR:   paint_color   <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry of outer and inset shapes
  logic signed [SW-1:0] cxo, cyo, hxo, hyo, cxi, cyi, hxi, hyi;
  logic signed [SW-1:0] iw_raw, ih_raw, ir_raw, iw, ih;
  logic [CB-2:0]        ir;
  logic signed [SW-1:0] p2x, p2y;

  always_comb begin
    iw_raw = SW'(rect_width) - SW'({stroke_width, 1'b0});
    ih_raw = SW'(rect_height) - SW'({stroke_width, 1'b0});
    ir_raw = SW'(corner_radius) - SW'(stroke_width);
    iw     = iw_raw[SW-1] ? '0 : iw_raw;
    ih     = ih_raw[SW-1] ? '0 : ih_raw;
    ir     = ir_raw[SW-1] ? '0 : ir_raw[CB-2:0];
    cxo    = SW'({rect_left, 1'b0}) + SW'(rect_width);
    cyo    = SW'({rect_top, 1'b0}) + SW'(rect_height);
    hxo    = SW'(rect_width) - SW'({corner_radius, 1'b0});
    hyo    = SW'(rect_height) - SW'({corner_radius, 1'b0});
    cxi    = SW'({rect_left, 1'b0}) + SW'({stroke_width, 1'b0}) + iw;
    cyi    = SW'({rect_top, 1'b0}) + SW'({stroke_width, 1'b0}) + ih;
    hxi    = iw - SW'({ir, 1'b0});
    hyi    = ih - SW'({ir, 1'b0});
    p2x    = SW'({pixel_x, 1'b1});
    p2y    = SW'({pixel_y, 1'b1});
  end

  logic       adv;
  logic [1:0] cnt;

  assign adv      = (cnt != 2'd2);
  assign in_ready = adv;

  logic signed [DW-1:0] dist_o, dist_i;

  rrab_sdf #(.CB(CB), .FB(FB), .SW(SW), .QW(QW), .RW(RW), .DW(DW)) u_sdf_outer (
    .clk (clk), .en (adv), .p2x (p2x), .p2y (p2y), .cx (cxo), .cy (cyo),
    .hx (hxo), .hy (hyo), .rad (corner_radius), .distance (dist_o)
  );

  rrab_sdf #(.CB(CB), .FB(FB), .SW(SW), .QW(QW), .RW(RW), .DW(DW)) u_sdf_inner (
    .clk (clk), .en (adv), .p2x (p2x), .p2y (p2y), .cx (cxi), .cy (cyi),
    .hx (hxi), .hy (hyi), .rad (ir), .distance (dist_i)
  );

  logic             v_sd   [LSD];
  logic [PIX_W-1:0] dst_sd [LSD];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LSD; i++) v_sd[i] <= 1'b0;
    end else if (adv) begin
      v_sd[0] <= in_valid;
      for (int i = 1; i < LSD; i++) v_sd[i] <= v_sd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dst_sd[0] <= dest_pixel;
      for (int i = 1; i < LSD; i++) dst_sd[i] <= dst_sd[i-1];
    end
  end

  // coverage
  logic signed [DW-1:0] cov_o, cov_i;
  logic [FB:0]          cl_o, cl_i, cv_next;
  logic                 pos_next;

  always_comb begin
    cov_o = HALF_D - dist_o;
    cov_i = HALF_D - dist_i;
    cl_o  = (cov_o <= 0) ? '0 : ((cov_o > ONE_D) ? ONE_C : cov_o[FB:0]);
    cl_i  = (cov_i <= 0) ? '0 : ((cov_i > ONE_D) ? ONE_C : cov_i[FB:0]);
    if (outline_mode) begin
      pos_next = cl_o > cl_i;
      cv_next  = cl_o - cl_i;
    end else begin
      pos_next = cov_o > 0;
      cv_next  = cl_o;
    end
  end

  logic             v1, v2, v3;
  logic             pos1, pos2, pos3;
  logic [FB:0]      cv1;
  logic [PIX_W-1:0] dst1, dst2, dst3;
  logic [WW-1:0]    wgt2;
  logic [CH_W-1:0]  ea2, ea3;
  logic [15:0]      m3 [4];
  logic [CH_W-1:0]  sa;
  logic [FB+CH_W:0] ea_prod;
  logic [CH_W-1:0]  src_ch [4];
  logic [CH_W-1:0]  dst_ch [4];

  assign sa      = paint_color[31:24];
  assign ea_prod = (FB+CH_W+1)'(dst1[31:24]) * (FB+CH_W+1)'(ONE_C - cv1);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      src_ch[c] = paint_color[c*CH_W +: CH_W];
      dst_ch[c] = dst2[c*CH_W +: CH_W];
    end
    src_ch[3] = CH_MAX;
    dst_ch[3] = dst2[31:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= v_sd[LSD-1];
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos1 <= pos_next;
      cv1  <= cv_next;
      dst1 <= dst_sd[LSD-1];
      pos2 <= pos1;
      dst2 <= dst1;
      wgt2 <= WW'(cv1) * WW'(sa);
      ea2  <= ea_prod[FB +: CH_W];
      pos3 <= pos2;
      dst3 <= dst2;
      ea3  <= ea2;
      for (int c = 0; c < 4; c++) begin
        m3[c] <= 16'((((FB+16)'(src_ch[c]) * (FB+16)'(wgt2))
                    + ((FB+16)'(dst_ch[c]) * (FB+16)'(DEN - wgt2))) >> FB);
      end
    end
  end

  // blend result
  logic [31:0]      q_prod [4];
  logic [PIX_W-1:0] res;
  logic             tch;

  always_comb begin
    for (int c = 0; c < 4; c++) q_prod[c] = 32'(m3[c]) * 32'(RECIP_255);
    if (!pos3) begin
      res = dst3;
    end else if (sa == '0) begin
      res = {ea3, dst3[23:0]};
    end else begin
      res = {q_prod[3][RECIP_SHIFT +: CH_W], q_prod[2][RECIP_SHIFT +: CH_W],
             q_prod[1][RECIP_SHIFT +: CH_W], q_prod[0][RECIP_SHIFT +: CH_W]};
    end
    tch = (res != dst3);
  end

  // two-entry output buffer
  logic [PIX_W-1:0] buf_px [2];
  logic             buf_t  [2];
  logic             push, pop;

  assign push      = v3 && adv;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign new_pixel = buf_px[0];
  assign touched   = buf_t[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        buf_px[0] <= buf_px[1];
        buf_t[0]  <= buf_t[1];
      end else begin
        buf_px[0] <= res;
        buf_t[0]  <= tch;
      end
      buf_px[1] <= res;
      buf_t[1]  <= tch;
    end else if (push) begin
      if (cnt == 2'd0) begin
        buf_px[0] <= res;
        buf_t[0]  <= tch;
      end else begin
        buf_px[1] <= res;
        buf_t[1]  <= tch;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("buffered transaction dropped");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) && !out_ready |=> $stable(v3) && (cnt == 2'd2))
    else $error("pipeline moved while output buffer full");

endmodule

// ----- tb/sv/rrab_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrab_checker
// Watches the pixel and result channels and the register port, predicts each
// blended pixel from the rounded-rectangle coverage, and compares in order.
// ----------------------------------------------------------------------------
module rrab_checker
  import rrab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [11:0]           pixel_x,
  input  logic [11:0]           pixel_y,
  input  logic [PIX_W-1:0]      dest_pixel,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PIX_W-1:0]      new_pixel,
  input  logic                  touched,
  output int                    fail_count,
  output int                    pending,
  output int                    touched_count
);

  localparam longint ONE  = 256;
  localparam longint HALF = 128;

  typedef struct packed {
    logic [31:0] pix;
    logic        hit;
  } blend_t;

  logic [11:0] left_q, top_q;
  logic [12:0] width_q, height_q;
  logic [10:0] radius_q;
  logic        outline_q;
  logic [7:0]  stroke_q;
  logic [31:0] paint_q;
  blend_t      blend_q[$];

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint shape_dist(longint px, longint py, longint rx, longint ry,
                                        longint w, longint h, longint r);
    longint dx, dy, qx, qy, ox, oy, m;
    dx = px - (2 * rx + w);
    dy = py - (2 * ry + h);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    qx = dx - (w - 2 * r);
    qy = dy - (h - 2 * r);
    ox = (qx > 0 ? qx : 0) * HALF;
    oy = (qy > 0 ? qy : 0) * HALF;
    m = qx > qy ? qx : qy;
    return root_floor(ox * ox + oy * oy) + (m < 0 ? m : 0) * HALF - r * ONE;
  endfunction

  function automatic longint clamp_unit(longint c);
    if (c < 0) return 0;
    if (c > ONE) return ONE;
    return c;
  endfunction

  function automatic longint mix(longint s, longint d, longint w);
    return (s * w + d * (255 * ONE - w)) / (255 * ONE);
  endfunction

  function automatic blend_t predict_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] dst);
    longint px, py, cov, t, iw, ih, ir, sa, da, na;
    blend_t b;
    px = 2 * longint'(x) + 1;
    py = 2 * longint'(y) + 1;
    if (outline_q) begin
      t = stroke_q;
      iw = width_q - 2 * t;
      ih = height_q - 2 * t;
      ir = radius_q - t;
      if (iw < 0) iw = 0;
      if (ih < 0) ih = 0;
      if (ir < 0) ir = 0;
      cov = clamp_unit(HALF - shape_dist(px, py, left_q, top_q, width_q, height_q, radius_q))
          - clamp_unit(HALF - shape_dist(px, py, left_q + t, top_q + t, iw, ih, ir));
    end else begin
      cov = HALF - shape_dist(px, py, left_q, top_q, width_q, height_q, radius_q);
      if (cov > ONE) cov = ONE;
    end
    b.pix = dst;
    if (cov > 0) begin
      sa = paint_q[31:24];
      da = dst[31:24];
      if (sa == 0) begin
        na = (da * (ONE - cov)) >> 8;
        b.pix = {na[7:0], dst[23:0]};
      end else begin
        b.pix[7:0]   = 8'(mix(paint_q[7:0], dst[7:0], cov * sa));
        b.pix[15:8]  = 8'(mix(paint_q[15:8], dst[15:8], cov * sa));
        b.pix[23:16] = 8'(mix(paint_q[23:16], dst[23:16], cov * sa));
        na = mix(255, da, cov * sa);
        b.pix[31:24] = na > 255 ? 8'd255 : na[7:0];
      end
    end
    b.hit = b.pix != dst;
    return b;
  endfunction

  always @(posedge clk) begin
    blend_t exp_b;
    if (rst) begin
      left_q <= '0; top_q <= '0; width_q <= '0; height_q <= '0;
      radius_q <= '0; outline_q <= 1'b0; stroke_q <= STROKE_RESET; paint_q <= '0;
      blend_q.delete();
      fail_count <= 0;
      touched_count <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) blend_q.push_back(predict_pixel(pixel_x, pixel_y, dest_pixel));
      if (out_valid && out_ready) begin
        if (blend_q.size() == 0) begin
          $display("%0t: unexpected result new_pixel=%h touched=%0d", $time, new_pixel,
                   touched);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = blend_q.pop_front();
          if (touched) touched_count <= touched_count + 1;
          if (exp_b.pix !== new_pixel || exp_b.hit !== touched) begin
            $display("%0t: mismatch new_pixel exp=%h got=%h touched exp=%0d got=%0d", $time,
                     exp_b.pix, new_pixel, exp_b.hit, touched);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= blend_q.size();
      if (cfg_write) begin
        case (cfg_index)
          CFG_RECT_LEFT:     left_q <= cfg_data[11:0];
          CFG_RECT_TOP:      top_q <= cfg_data[11:0];
          CFG_RECT_WIDTH:    width_q <= cfg_data[12:0];
          CFG_RECT_HEIGHT:   height_q <= cfg_data[12:0];
          CFG_CORNER_RADIUS: radius_q <= cfg_data[10:0];
          CFG_OUTLINE_MODE:  outline_q <= cfg_data[0];
          CFG_STROKE_WIDTH:  stroke_q <= cfg_data[7:0];
          CFG_PAINT_COLOR:   paint_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel streams over several rectangle, outline and paint settings with
// varied handshake pressure; the checker compares every blended pixel.
// ----------------------------------------------------------------------------
module tb_top;
  import rrab_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [11:0]           pixel_x = '0;
  logic [11:0]           pixel_y = '0;
  logic [PIX_W-1:0]      dest_pixel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      new_pixel;
  logic                  touched;
  int                    fail_count, pending, touched_count;
  int                    send_idle = 0, recv_stall = 0, sent = 0;
  logic                  hold_go = 1'b0;
  logic                  hold_on = 1'b0;
  logic [11:0]           rl, rt;
  logic [12:0]           rw, rh;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rounded_rect_aa_raster_blend dut (.*);

  rrab_checker chk (.*);

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_on) out_ready <= 1'b0;
    else out_ready <= $urandom_range(99) >= recv_stall;
  end

  // hold off the receiver for a long stretch
  initial begin
    wait (hold_go);
    @(negedge clk);
    hold_on <= 1'b1;
    repeat (300) @(negedge clk);
    hold_on <= 1'b0;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    dest_pixel <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic shape(logic [11:0] l, logic [11:0] t, logic [12:0] w, logic [12:0] h,
                       logic [10:0] r, logic om, logic [7:0] sw, logic [31:0] col);
    drain();
    write_reg(CFG_RECT_LEFT, ({$urandom} & 32'hFFFF_F000) | 32'(l));
    write_reg(CFG_RECT_TOP, 32'(t));
    write_reg(CFG_RECT_WIDTH, ({$urandom} & 32'hFFFF_E000) | 32'(w));
    write_reg(CFG_RECT_HEIGHT, 32'(h));
    write_reg(CFG_CORNER_RADIUS, 32'(r));
    write_reg(CFG_OUTLINE_MODE, {31'h0, om});
    write_reg(CFG_STROKE_WIDTH, 32'(sw));
    write_reg(CFG_PAINT_COLOR, col);
    rl = l; rt = t; rw = w; rh = h;
  endtask

  task automatic near_pixels(int n);
    int x, y;
    repeat (n) begin
      x = int'(rl) + $urandom_range(rw + 8) - 4;
      y = int'(rt) + $urandom_range(rh + 8) - 4;
      if ($urandom_range(9) == 0) begin
        x = $urandom;
        y = $urandom;
      end
      send_pixel(x[11:0], y[11:0], $urandom);
    end
  endtask

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_pixel(12'd0, 12'd0, 32'hFFFF_FFFF);
    shape(12'd10, 12'd10, 13'd20, 13'd12, 11'd4, 1'b0, 8'd1, 32'h80FF_4020);
    send_pixel(12'd15, 12'd15, 32'h0000_0000);
    send_pixel(12'd9, 12'd15, 32'hFFFF_FFFF);
    send_pixel(12'd10, 12'd10, 32'h1234_5678);
    send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
    shape(12'd4095, 12'd4095, 13'd4096, 13'd4096, 11'd2047, 1'b1, 8'd255, 32'hFF00_00FF);
    send_pixel(12'd4095, 12'd4095, 32'h00FF_FF00);
    send_pixel(12'd0, 12'd4095, 32'hAAAA_5555);
    shape(12'd0, 12'd0, 13'd0, 13'd0, 11'd0, 1'b0, 8'd0, 32'h00FF_FFFF);
    send_pixel(12'd0, 12'd0, 32'hFFFF_FFFF);
    shape(12'd5, 12'd5, 13'd30, 13'd30, 11'd2047, 1'b1, 8'd3, 32'h0000_0000);
    near_pixels(10);
    shape(12'd5, 12'd5, 13'd6, 13'd40, 11'd2, 1'b1, 8'd10, 32'hFF12_3456);
    near_pixels(8);
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 57; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 57; end
        default: begin send_idle = 36; recv_stall = 36; end
      endcase
      shape(12'($urandom_range(4095)), 12'($urandom_range(4095)),
            13'($urandom_range(60)), 13'($urandom_range(60)),
            11'($urandom_range(ph == 11 ? 2047 : 20)), 1'($urandom_range(1)),
            8'($urandom_range(ph == 7 ? 255 : 8)),
            ($urandom_range(3) == 0) ? {8'h00, 24'($urandom)} : $urandom);
      if (ph == 4) hold_go = 1'b1;
      near_pixels(45);
    end
    drain();
    $display("Sent %0d pixels over directed and random shapes; %0d results touched.", sent,
             touched_count);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
